>>> src/mts_pkg.sv
// mts_pkg: shared types and constants of the min-tracking stack
// used by mts_cell, min_tracking_stack_core and mts_checker
package mts_pkg;

  // stack size and the width of the entry count (holds 0 to StackDepth)
  localparam int unsigned StackDepth = 256;
  localparam int unsigned CountW     = $clog2(StackDepth + 1);

  localparam int unsigned DataW      = 32;
  localparam int unsigned OpW        = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned EntryCntW  = 9;

  // popped word reported on underflow
  localparam logic signed [DataW-1:0] PopUnderflowValue = -32'sd1;

  typedef enum logic [OpW-1:0] {
    OpPush  = 2'd0,
    OpPop   = 2'd1,
    OpQuery = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk        = 2'd0,
    StOverflow  = 2'd1,
    StUnderflow = 2'd2
  } status_e;

  // one stack entry: stored value and minimum at and below it
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] min;
  } entry_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

>>> src/mts_cell.sv
// mts_cell: one stack slot; shifts down on push and up on pop
// depends on mts_pkg
module mts_cell (
  input  logic                clk_i,
  input  mts_pkg::shift_ctl_t ctl_i,
  input  mts_pkg::entry_t     above_i,
  input  mts_pkg::entry_t     below_i,
  output mts_pkg::entry_t     entry_o
);

  mts_pkg::entry_t entry_q;
  mts_pkg::entry_t entry_d;

  // take the neighbor above on push, the neighbor below on pop
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.push) begin
      entry_d = above_i;
    end else if (ctl_i.pop) begin
      entry_d = below_i;
    end
  end

  // slot payload, undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> src/min_tracking_stack_core.sv
// min_tracking_stack_core: LIFO stack of signed words with running minimum
// depends on mts_pkg and mts_cell
//
//  channel | handshake               | word
//  --------+-------------------------+---------------------------------------------
//  in      | in_valid_i / in_ready_o | op_i, push_value_i
//  out     | out_valid_o/out_ready_i | popped_value_o, status_o, top_value_o,
//          |                         | min_value_o, entry_count_o, is_empty_o
//
// a word is accepted, the cell chain shifts and the
// result lands in the output register at the same edge, so one word per cycle
// is sustained while the output is taken each cycle.
// the top of stack is always cell 0, so results read cells 0 and 1 only.
// reset clears the entry count and the output valid; cell contents are
// undefined and never read before written.
// a stalled output holds its result and blocks input until taken.
module min_tracking_stack_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [mts_pkg::OpW-1:0]               op_i,
  input  logic signed [mts_pkg::DataW-1:0]      push_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mts_pkg::DataW-1:0]      popped_value_o,
  output logic [mts_pkg::StatusW-1:0]           status_o,
  output logic signed [mts_pkg::DataW-1:0]      top_value_o,
  output logic signed [mts_pkg::DataW-1:0]      min_value_o,
  output logic [mts_pkg::EntryCntW-1:0]         entry_count_o,
  output logic                                  is_empty_o
);

  localparam int unsigned Depth = mts_pkg::StackDepth;
  localparam int unsigned CntW  = mts_pkg::CountW;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            out_valid_q;
  logic            accept;
  logic            full;
  logic            empty;

  mts_pkg::shift_ctl_t ctl;
  mts_pkg::entry_t     new_entry;
  mts_pkg::entry_t     cell_data [Depth];
  mts_pkg::entry_t     res_entry;
  mts_pkg::status_e    res_status;
  logic signed [mts_pkg::DataW-1:0] res_popped;

  mts_pkg::status_e                 status_q;
  logic signed [mts_pkg::DataW-1:0] popped_q;
  logic signed [mts_pkg::DataW-1:0] top_q;
  logic signed [mts_pkg::DataW-1:0] min_q;
  logic [CntW-1:0]                  cnt_out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(Depth));
  assign empty      = (count_q == '0);

  // entry built by a push: minimum with the one below, ties take the pushed value
  always_comb begin
    new_entry.value = push_value_i;
    new_entry.min   = push_value_i;
    if (!empty && (cell_data[0].min < push_value_i)) begin
      new_entry.min = cell_data[0].min;
    end
  end

  // op decode, shift control and result word
  always_comb begin
    ctl        = '0;
    count_d    = count_q;
    res_status = mts_pkg::StOk;
    res_popped = '0;
    res_entry  = empty ? '0 : cell_data[0];
    unique case (mts_pkg::op_e'(op_i))
      mts_pkg::OpPush: begin
        if (full) begin
          res_status = mts_pkg::StOverflow;
        end else begin
          ctl.push  = accept;
          count_d   = count_q + CntW'(1);
          res_entry = new_entry;
        end
      end
      mts_pkg::OpPop: begin
        if (empty) begin
          res_status = mts_pkg::StUnderflow;
          res_popped = mts_pkg::PopUnderflowValue;
        end else begin
          ctl.pop    = accept;
          count_d    = count_q - CntW'(1);
          res_popped = cell_data[0].value;
          res_entry  = (count_q > CntW'(1)) ? cell_data[1] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // chain of slots, cell 0 is the top of stack
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    mts_pkg::entry_t above;
    mts_pkg::entry_t below;
    if (i == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_rest
      assign below = cell_data[i+1];
    end
    mts_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .above_i (above),
      .below_i (below),
      .entry_o (cell_data[i])
    );
  end

  // entry count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= res_status;
      popped_q  <= res_popped;
      top_q     <= res_entry.value;
      min_q     <= res_entry.min;
      cnt_out_q <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign top_value_o    = top_q;
  assign min_value_o    = min_q;
  assign entry_count_o  = mts_pkg::EntryCntW'(cnt_out_q);
  assign is_empty_o     = (cnt_out_q == '0);

endmodule

>>> src/mts_checker.sv
// mts_checker: port-level checks of min_tracking_stack_core, bound to it
// depends on mts_pkg
module mts_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [mts_pkg::DataW-1:0]      popped_value_o,
  input logic [mts_pkg::StatusW-1:0]           status_o,
  input logic signed [mts_pkg::DataW-1:0]      top_value_o,
  input logic signed [mts_pkg::DataW-1:0]      min_value_o,
  input logic [mts_pkg::EntryCntW-1:0]         entry_count_o,
  input logic                                  is_empty_o
);

  // a stalled result keeps its valid, top, minimum and count
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(top_value_o)
      && $stable(min_value_o) && $stable(entry_count_o))
    else $error("stalled output word changed");

  // empty flag agrees with the count
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag and count disagree");

  // an empty stack reports zero top and minimum
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (top_value_o == '0) && (min_value_o == '0))
    else $error("empty stack reports nonzero top or minimum");

  // underflow only on an empty stack, with all-ones popped word
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == mts_pkg::StUnderflow)
      |-> is_empty_o && (popped_value_o == mts_pkg::PopUnderflowValue))
    else $error("bad underflow result");

  // minimum never exceeds the top value
  a_min_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_value_o <= top_value_o))
    else $error("minimum above top value");

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (.*);
